// ----- rtl/bsht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsht_pkg
// Shared constants, operation and status codes, and control structs.
// ----------------------------------------------------------------------------
package bsht_pkg;

  localparam int unsigned INDEX_BITS_DEF   = 10;
  localparam int unsigned CODE_WIDTH_DEF   = 20;
  localparam int unsigned VALUE_WIDTH_DEF  = 8;
  localparam int unsigned BUCKET_DEPTH_DEF = 16;

  localparam int unsigned KEY_W   = 30;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned IVAL_W  = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 15;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

  localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET_PROOF  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ_PROOF = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLR_PROOFS = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLR_ALL    = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic accept;
    logic load;
    logic cmp;
    logic miss;
    logic shift_rd;
    logic shift_wr;
    logic ins_wr;
    logic set_prf;
    logic cnt_clr;
    logic sweep_prf;
    logic sweep_fill;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              lo_lt_hi;
    logic              code_eq;
    logic              full;
    logic              hit;
    logic              shift_more;
    logic              prf_bit;
    logic              sweep_last;
  } sts_t;

endpackage

// ----- rtl/bsht_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsht_if
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsht_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [29:0] key;
  logic [7:0]  value;

  modport source (output valid, output kind, output key, output value, input ready);
  modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface bsht_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [7:0]  value_out;
  logic        proof;
  logic        changed;
  logic [14:0] entry_total;
  logic [14:0] proof_total;

  modport source (output valid, output status, output found, output value_out,
                  output proof, output changed, output entry_total,
                  output proof_total, input ready);
  modport sink   (input valid, input status, input found, input value_out,
                  input proof, input changed, input entry_total,
                  input proof_total, output ready);
endinterface

// ----- rtl/bsht_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsht_ctrl
// Operation sequencer: load, binary search, shift, write, sweep, respond.
// ----------------------------------------------------------------------------
module bsht_ctrl
  import bsht_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_LOADW = 4'd3;
  localparam logic [3:0] S_SRCH  = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_EXEC  = 4'd6;
  localparam logic [3:0] S_SHRD  = 4'd7;
  localparam logic [3:0] S_SHWR  = 4'd8;
  localparam logic [3:0] S_INS   = 4'd9;
  localparam logic [3:0] S_SWEEP = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state_q, state_d;
  logic       ovld_q, ovld_d;
  logic       slot_free;

  assign slot_free   = !ovld_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovld_q;

  always_comb begin
    state_d = state_q;
    ovld_d  = ovld_q && !out_ready_i;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep_fill = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_LOAD: state_d = S_LOADW;
      S_LOADW: begin
        cmd_o.load = 1'b1;
        if (sts_i.kind <= KIND_READ_PROOF) state_d = S_SRCH;
        else state_d = S_EXEC;
      end
      S_SRCH: begin
        if (sts_i.lo_lt_hi) state_d = S_CMP;
        else begin
          cmd_o.miss = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (sts_i.code_eq) state_d = S_EXEC;
        else state_d = S_SRCH;
      end
      S_EXEC: begin
        state_d = S_DONE;
        priority if (sts_i.kind == KIND_INSERT) begin
          if (!sts_i.hit && !sts_i.full) state_d = S_SHRD;
        end else if (sts_i.kind == KIND_SET_PROOF) begin
          if (sts_i.hit && !sts_i.prf_bit) cmd_o.set_prf = 1'b1;
        end else if (sts_i.kind == KIND_CLR_PROOFS || sts_i.kind == KIND_CLR_ALL) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = S_SWEEP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SHRD: begin
        if (sts_i.shift_more) begin
          cmd_o.shift_rd = 1'b1;
          state_d = S_SHWR;
        end else begin
          state_d = S_INS;
        end
      end
      S_SHWR: begin
        cmd_o.shift_wr = 1'b1;
        state_d = S_SHRD;
      end
      S_INS: begin
        cmd_o.ins_wr = 1'b1;
        state_d = S_DONE;
      end
      S_SWEEP: begin
        if (sts_i.kind == KIND_CLR_PROOFS) cmd_o.sweep_prf = 1'b1;
        else cmd_o.sweep_fill = 1'b1;
        if (sts_i.sweep_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.res_load = 1'b1;
          ovld_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

// ----- rtl/bsht_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsht_dp
// Datapath: entry, fill and proof-row memories, search registers, counts.
// ----------------------------------------------------------------------------
module bsht_dp
  import bsht_pkg::*;
#(
  parameter int unsigned INDEX_BITS   = INDEX_BITS_DEF,
  parameter int unsigned CODE_WIDTH   = CODE_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH  = VALUE_WIDTH_DEF,
  parameter int unsigned BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [IVAL_W-1:0]   value_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic [STAT_W-1:0]   status_o,
  output logic                found_o,
  output logic [7:0]          value_out_o,
  output logic                proof_o,
  output logic                changed_o,
  output logic [COUNT_W-1:0]  entry_total_o,
  output logic [COUNT_W-1:0]  proof_total_o
);

  localparam int unsigned NUM_BKT = 1 << INDEX_BITS;
  localparam int unsigned SLOT_W  = $clog2(BUCKET_DEPTH);
  localparam int unsigned FILL_W  = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned NUM_ENT = NUM_BKT << SLOT_W;
  localparam int unsigned ENT_W   = CODE_WIDTH + VALUE_WIDTH;
  localparam int unsigned ADDR_W  = INDEX_BITS + SLOT_W;
  localparam logic [FILL_W-1:0] DEPTH_C = FILL_W'(BUCKET_DEPTH);

  logic [ENT_W-1:0]        ent_mem [NUM_ENT];
  logic [FILL_W-1:0]       fill_mem [NUM_BKT];
  logic [BUCKET_DEPTH-1:0] prf_mem [NUM_BKT];

  logic [ENT_W-1:0]        ent_rd_q;
  logic [FILL_W-1:0]       fill_rd_q;
  logic [BUCKET_DEPTH-1:0] prf_rd_q;

  logic [KIND_W-1:0]       kind_q;
  logic [CODE_WIDTH-1:0]   code_q;
  logic [INDEX_BITS-1:0]   bkt_q;
  logic [VALUE_WIDTH-1:0]  val_q;
  logic [VALUE_WIDTH-1:0]  vhit_q;
  logic [FILL_W-1:0]       n_q, lo_q, hi_q, pos_q, i_q;
  logic                    hit_q, chg_q;
  logic [BUCKET_DEPTH-1:0] row_q, row_ins;
  logic [INDEX_BITS-1:0]   swp_q;
  logic [COUNT_W-1:0]      ecnt_q, pcnt_q;

  logic [63:0]             key64, key_sh;
  logic [15:0]             vin16, vout16;
  logic [FILL_W:0]         mid_sum;
  logic [FILL_W-1:0]       mid, i_dec;
  logic [CODE_WIDTH-1:0]   rd_code;
  logic [ADDR_W-1:0]       rd_addr;
  logic [SLOT_W-1:0]       pos_slot;
  logic                    prf_bit;

  assign key64    = 64'(key_i);
  assign key_sh   = key64 >> CODE_WIDTH;
  assign vin16    = 16'(value_i);
  assign vout16   = 16'(vhit_q);
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[FILL_W:1];
  assign i_dec    = i_q - FILL_W'(1);
  assign rd_code  = ent_rd_q[CODE_WIDTH-1:0];
  assign pos_slot = pos_q[SLOT_W-1:0];
  assign prf_bit  = row_q[pos_slot];
  assign rd_addr  = cmd_i.shift_rd ? {bkt_q, i_dec[SLOT_W-1:0]} : {bkt_q, mid[SLOT_W-1:0]};

  always_comb begin
    for (int j = 0; j < BUCKET_DEPTH; j++) begin
      if (FILL_W'(j) < pos_q) row_ins[j] = row_q[j];
      else if (FILL_W'(j) == pos_q) row_ins[j] = 1'b0;
      else row_ins[j] = row_q[(j > 0) ? j - 1 : 0];
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    ent_rd_q  <= ent_mem[rd_addr];
    fill_rd_q <= fill_mem[bkt_q];
    prf_rd_q  <= prf_mem[bkt_q];
    if (cmd_i.shift_wr) ent_mem[{bkt_q, i_q[SLOT_W-1:0]}] <= ent_rd_q;
    else if (cmd_i.ins_wr) ent_mem[{bkt_q, pos_slot}] <= {val_q, code_q};
    if (cmd_i.ins_wr) fill_mem[bkt_q] <= n_q + FILL_W'(1);
    else if (cmd_i.sweep_fill) fill_mem[swp_q] <= '0;
    if (cmd_i.ins_wr) prf_mem[bkt_q] <= row_ins;
    else if (cmd_i.set_prf) prf_mem[bkt_q] <= row_q | (BUCKET_DEPTH'(1) << pos_slot);
    else if (cmd_i.sweep_prf) prf_mem[swp_q] <= '0;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      code_q <= key64[CODE_WIDTH-1:0];
      bkt_q  <= key_sh[INDEX_BITS-1:0];
      val_q  <= vin16[VALUE_WIDTH-1:0];
      chg_q  <= 1'b0;
    end
    if (cmd_i.load) begin
      n_q   <= (fill_rd_q > DEPTH_C) ? DEPTH_C : fill_rd_q;
      i_q   <= (fill_rd_q > DEPTH_C) ? DEPTH_C : fill_rd_q;
      lo_q  <= '0;
      hi_q  <= (fill_rd_q > DEPTH_C) ? DEPTH_C : fill_rd_q;
      hit_q <= 1'b0;
      row_q <= prf_rd_q;
    end
    if (cmd_i.cmp) begin
      priority if (rd_code == code_q) begin
        hit_q  <= 1'b1;
        pos_q  <= mid;
        vhit_q <= ent_rd_q[ENT_W-1:CODE_WIDTH];
      end else if (rd_code < code_q) begin
        lo_q <= mid + FILL_W'(1);
      end else begin
        hi_q <= mid;
      end
    end
    if (cmd_i.miss) pos_q <= lo_q;
    if (cmd_i.shift_wr) i_q <= i_dec;
    if (cmd_i.set_prf) chg_q <= 1'b1;
    if (cmd_i.res_load) begin
      priority if (kind_q == KIND_INSERT) begin
        status_o <= hit_q ? ST_DUPLICATE : ((n_q >= DEPTH_C) ? ST_FULL : ST_OK);
      end else if (kind_q <= KIND_READ_PROOF) begin
        status_o <= hit_q ? ST_OK : ST_NOT_FOUND;
      end else begin
        status_o <= ST_OK;
      end
      found_o       <= (kind_q <= KIND_READ_PROOF) && hit_q;
      value_out_o   <= (kind_q == KIND_LOOKUP && hit_q) ? vout16[7:0] : 8'd0;
      proof_o       <= (kind_q == KIND_READ_PROOF) && hit_q && prf_bit;
      changed_o     <= chg_q;
      entry_total_o <= ecnt_q;
      proof_total_o <= pcnt_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swp_q  <= '0;
      ecnt_q <= '0;
      pcnt_q <= '0;
    end else begin
      if (cmd_i.sweep_fill || cmd_i.sweep_prf) swp_q <= swp_q + INDEX_BITS'(1);
      if (cmd_i.cnt_clr) begin
        pcnt_q <= '0;
        if (kind_q == KIND_CLR_ALL) ecnt_q <= '0;
      end
      if (cmd_i.ins_wr && ecnt_q != COUNT_MAX) ecnt_q <= ecnt_q + COUNT_W'(1);
      if (cmd_i.set_prf && pcnt_q != COUNT_MAX) pcnt_q <= pcnt_q + COUNT_W'(1);
    end
  end

  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.lo_lt_hi   = lo_q < hi_q;
    sts_o.code_eq    = rd_code == code_q;
    sts_o.full       = n_q >= DEPTH_C;
    sts_o.hit        = hit_q;
    sts_o.shift_more = i_q > pos_q;
    sts_o.prf_bit    = prf_bit;
    sts_o.sweep_last = swp_q == {INDEX_BITS{1'b1}};
  end

endmodule

// ----- rtl/bucketed_sorted_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_sorted_hash_table
// Hash table with sorted fixed-depth buckets searched by binary search.
// ----------------------------------------------------------------------------
// sequence: load the bucket, binary search of up to 5 probes; an insert then
//   shifts later entries up one slot and writes the new one; clears sweep all buckets
// throughput: one word at a time, set by the search and shift loops on the
//   single-port entry memory; a new word is taken while a result waits
// reset: a fill clearing pass over all 2^INDEX_BITS buckets, no words accepted
// ----------------------------------------------------------------------------
module bucketed_sorted_hash_table
  import bsht_pkg::*;
#(
  parameter int unsigned INDEX_BITS   = INDEX_BITS_DEF,
  parameter int unsigned CODE_WIDTH   = CODE_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH  = VALUE_WIDTH_DEF,
  parameter int unsigned BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  bsht_in_if.sink    in_ch,
  bsht_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  bsht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bsht_dp #(
    .INDEX_BITS   (INDEX_BITS),
    .CODE_WIDTH   (CODE_WIDTH),
    .VALUE_WIDTH  (VALUE_WIDTH),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (in_ch.kind),
    .key_i         (in_ch.key),
    .value_i       (in_ch.value),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (out_ch.status),
    .found_o       (out_ch.found),
    .value_out_o   (out_ch.value_out),
    .proof_o       (out_ch.proof),
    .changed_o     (out_ch.changed),
    .entry_total_o (out_ch.entry_total),
    .proof_total_o (out_ch.proof_total)
  );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed table operations into the hash table engine,
// keeps a behavioral copy of the buckets to predict every response word, and
// compares each response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import bsht_pkg::*;

  localparam int NB    = 1 << INDEX_BITS_DEF;
  localparam int DEPTH = BUCKET_DEPTH_DEF;
  localparam int CW    = CODE_WIDTH_DEF;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [IVAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [7:0]         value_out;
    logic               proof;
    logic               changed;
    logic [COUNT_W-1:0] entry_total;
    logic [COUNT_W-1:0] proof_total;
  } rsp_t;

  logic clk_i;
  logic rst_ni;

  bsht_in_if  in_ch ();
  bsht_out_if out_ch ();

  bucketed_sorted_hash_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow table
  logic [CW-1:0]  sh_code [NB][DEPTH];
  logic [7:0]     sh_val  [NB][DEPTH];
  logic           sh_prf  [NB][DEPTH];
  int             sh_fill [NB];
  int             sh_entries;
  int             sh_proofs;

  req_t pending_q[$];
  rsp_t expected_q[$];
  int   errors;
  int   idle_pct;
  bit   hold_send;
  bit   stim_done;
  bit   timed_out;
  int   quiet_cycles;

  function automatic rsp_t apply_op(req_t r);
    rsp_t o;
    int b, n, lo, hi, mid, pos;
    bit hit;
    logic [CW-1:0] code;
    o = '0;
    b = int'(r.key >> CW) % NB;
    code = r.key[CW-1:0];
    n = sh_fill[b];
    hit = 0;
    lo = 0;
    hi = n;
    pos = 0;
    if (r.kind <= KIND_READ_PROOF) begin
      while (lo < hi && !hit) begin
        mid = lo + (hi - lo) / 2;
        if (sh_code[b][mid] == code) begin
          hit = 1;
          pos = mid;
        end else if (sh_code[b][mid] < code) begin
          lo = mid + 1;
        end else begin
          hi = mid;
        end
      end
      if (!hit) pos = lo;
      o.found = hit;
    end
    case (r.kind)
      KIND_INSERT: begin
        if (hit) begin
          o.status = ST_DUPLICATE;
        end else if (n >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          for (int i = n; i > pos; i--) begin
            sh_code[b][i] = sh_code[b][i-1];
            sh_val[b][i]  = sh_val[b][i-1];
            sh_prf[b][i]  = sh_prf[b][i-1];
          end
          sh_code[b][pos] = code;
          sh_val[b][pos]  = r.value;
          sh_prf[b][pos]  = 1'b0;
          sh_fill[b]      = n + 1;
          if (sh_entries < 32767) sh_entries++;
        end
      end
      KIND_LOOKUP: begin
        if (hit) o.value_out = sh_val[b][pos];
        else o.status = ST_NOT_FOUND;
      end
      KIND_SET_PROOF: begin
        if (hit) begin
          if (!sh_prf[b][pos]) begin
            o.changed = 1'b1;
            sh_prf[b][pos] = 1'b1;
            if (sh_proofs < 32767) sh_proofs++;
          end
        end else begin
          o.status = ST_NOT_FOUND;
        end
      end
      KIND_READ_PROOF: begin
        if (hit) o.proof = sh_prf[b][pos];
        else o.status = ST_NOT_FOUND;
      end
      KIND_CLR_PROOFS: begin
        for (int i = 0; i < NB; i++)
          for (int j = 0; j < DEPTH; j++) sh_prf[i][j] = 1'b0;
        sh_proofs = 0;
      end
      KIND_CLR_ALL: begin
        for (int i = 0; i < NB; i++) sh_fill[i] = 0;
        sh_entries = 0;
        sh_proofs  = 0;
      end
      default: ;
    endcase
    o.entry_total = sh_entries[COUNT_W-1:0];
    o.proof_total = sh_proofs[COUNT_W-1:0];
    return o;
  endfunction

  function automatic req_t make_req(logic [2:0] k, int bkt, logic [CW-1:0] c,
                                    logic [7:0] v);
    req_t r;
    r.kind  = k;
    r.key   = {bkt[9:0], c};
    r.value = v;
    return r;
  endfunction

  // keys of a recent insert, reused so lookups and proofs hit
  logic [KEY_W-1:0] recent_keys[$];

  function automatic req_t random_req();
    req_t r;
    int sel;
    sel = $urandom_range(0, 99);
    r.value = 8'($urandom);
    r.key = {10'($urandom_range(0, 7)), 17'($urandom), 3'($urandom)};
    if ($urandom_range(0, 9) == 0) r.key = 30'($urandom);
    if (sel < 35) begin
      r.kind = KIND_INSERT;
      if (recent_keys.size() > 0 && $urandom_range(0, 4) == 0)
        r.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      else
        recent_keys.push_back(r.key);
      if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    end else if (sel < 97) begin
      r.kind = 3'($urandom_range(1, 3));
      if (recent_keys.size() > 0 && $urandom_range(0, 3) != 0)
        r.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    end else if (sel < 98) begin
      r.kind = KIND_CLR_PROOFS;
    end else if (sel < 99) begin
      r.kind = KIND_CLR_ALL;
      recent_keys.delete();
    end else begin
      r.kind = 3'($urandom_range(6, 7));
    end
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    req_t r;
    rst_ni = 1'b0;
    idle_pct = 8;
    hold_send = 1'b0;
    stim_done = 1'b0;
    sh_entries = 0;
    sh_proofs = 0;
    for (int i = 0; i < NB; i++) sh_fill[i] = 0;
    // directed: extremes, every kind, full bucket, duplicates, absent keys
    pending_q.push_back(make_req(KIND_LOOKUP, 0, '0, 8'h00));
    pending_q.push_back(make_req(KIND_INSERT, 0, '0, 8'hFF));
    pending_q.push_back(make_req(KIND_INSERT, 1023, '1, 8'h00));
    pending_q.push_back(make_req(KIND_INSERT, 0, '0, 8'h55));
    pending_q.push_back(make_req(KIND_LOOKUP, 0, '0, 8'h00));
    pending_q.push_back(make_req(KIND_LOOKUP, 1023, '1, 8'hFF));
    pending_q.push_back(make_req(KIND_SET_PROOF, 1023, '1, 8'h00));
    pending_q.push_back(make_req(KIND_SET_PROOF, 1023, '1, 8'h00));
    pending_q.push_back(make_req(KIND_READ_PROOF, 1023, '1, 8'h00));
    pending_q.push_back(make_req(KIND_SET_PROOF, 5, 20'h12345, 8'h00));
    pending_q.push_back(make_req(KIND_READ_PROOF, 5, 20'h12345, 8'h00));
    for (int i = 0; i < 17; i++)
      pending_q.push_back(make_req(KIND_INSERT, 7, 20'((i * 7919) % 97), 8'(i)));
    pending_q.push_back(make_req(KIND_CLR_PROOFS, 0, '0, 8'h00));
    pending_q.push_back(make_req(KIND_READ_PROOF, 1023, '1, 8'h00));
    pending_q.push_back(make_req(3'd6, 0, '0, 8'h00));
    pending_q.push_back(make_req(3'd7, 1023, '1, 8'hFF));
    pending_q.push_back(make_req(KIND_CLR_ALL, 0, '0, 8'h00));
    pending_q.push_back(make_req(KIND_LOOKUP, 0, '0, 8'h00));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0);
    for (int i = 0; i < 820; i++) begin
      if (i == 200) begin
        wait (pending_q.size() == 0);
        hold_send = 1'b1;
        wait (!in_ch.valid && expected_q.size() == 0);
        hold_send = 1'b0;
      end
      if (i == 400) idle_pct = 0;
      if (i == 550) idle_pct = 8;
      r = random_req();
      pending_q.push_back(r);
      if (pending_q.size() > 4) wait (pending_q.size() <= 4);
    end
    wait (pending_q.size() == 0 && !in_ch.valid);
    stim_done = 1'b1;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.kind  <= '0;
      in_ch.key   <= '0;
      in_ch.value <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(apply_op(req_t'({in_ch.kind, in_ch.key, in_ch.value})));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_q.size() > 0 && !hold_send &&
            $urandom_range(0, 99) >= idle_pct) begin
          req_t r;
          r = pending_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.kind  <= r.kind;
          in_ch.key   <= r.key;
          in_ch.value <= r.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        rsp_t got, want;
        got = {out_ch.status, out_ch.found, out_ch.value_out, out_ch.proof,
               out_ch.changed, out_ch.entry_total, out_ch.proof_total};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
            errors++;
          end
          if (got.value_out !== want.value_out) begin
            $display("%0t: value_out expected %0d actual %0d", $time,
                     want.value_out, got.value_out);
            errors++;
          end
          if (got.proof !== want.proof) begin
            $display("%0t: proof expected %0d actual %0d", $time, want.proof, got.proof);
            errors++;
          end
          if (got.changed !== want.changed) begin
            $display("%0t: changed expected %0d actual %0d", $time,
                     want.changed, got.changed);
            errors++;
          end
          if (got.entry_total !== want.entry_total) begin
            $display("%0t: entry_total expected %0d actual %0d", $time,
                     want.entry_total, got.entry_total);
            errors++;
          end
          if (got.proof_total !== want.proof_total) begin
            $display("%0t: proof_total expected %0d actual %0d", $time,
                     want.proof_total, got.proof_total);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // watchdog and end of run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    fork
      begin
        wait (stim_done && expected_q.size() == 0);
        repeat (200) @(posedge clk_i);
      end
      begin
        wait (quiet_cycles >= 20000);
        timed_out = 1'b1;
      end
    join_any
    if (errors == 0 && !timed_out) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
